@@ hdl/aabb_pkg.sv @@
`default_nettype none

package aabb_pkg;

  // Field widths.
  localparam int unsigned CoordBits = 16;
  localparam int unsigned CoefBits  = 16;
  localparam int unsigned FracShift = 12;
  localparam int unsigned RegBits   = 48;
  localparam int unsigned NumAxes   = 3;

  // A Q4.12 by Q16.0 product, the term left after the fraction shift,
  // and the exact sum of the translation and three terms.
  localparam int unsigned ProdBits = CoefBits + CoordBits;
  localparam int unsigned TermBits = ProdBits - FracShift;
  localparam int unsigned SumBits  = TermBits + 2;

  localparam int unsigned CfgIdxBits = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    RegRowX   = 3'd0,
    RegRowY   = 3'd1,
    RegRowZ   = 3'd2,
    RegTrans  = 3'd3,
    RegRefMin = 3'd4,
    RegRefMax = 3'd5
  } cfg_reg_e;

  // Reset values: identity rows, no translation, reference box at the origin.
  localparam logic [RegBits-1:0] RowXReset = 48'h0000_0000_1000;
  localparam logic [RegBits-1:0] RowYReset = 48'h0000_1000_0000;
  localparam logic [RegBits-1:0] RowZReset = 48'h1000_0000_0000;

  typedef logic signed [CoordBits-1:0] coord_t;

  // One input word: the local box.
  typedef struct packed {
    logic signed [CoordBits-1:0] local_min_x;
    logic signed [CoordBits-1:0] local_min_y;
    logic signed [CoordBits-1:0] local_min_z;
    logic signed [CoordBits-1:0] local_max_x;
    logic signed [CoordBits-1:0] local_max_y;
    logic signed [CoordBits-1:0] local_max_z;
  } aabb_in_t;

  // One output word: the world box and the overlap flag.
  typedef struct packed {
    logic signed [CoordBits-1:0] world_min_x;
    logic signed [CoordBits-1:0] world_min_y;
    logic signed [CoordBits-1:0] world_min_z;
    logic signed [CoordBits-1:0] world_max_x;
    logic signed [CoordBits-1:0] world_max_y;
    logic signed [CoordBits-1:0] world_max_z;
    logic                        overlaps_reference;
  } aabb_out_t;

  // Result of one world axis.
  typedef struct packed {
    coord_t wmin;
    coord_t wmax;
    logic   hit;
  } axis_res_t;

endpackage

`default_nettype wire

@@ hdl/aabb_transform_overlap.sv @@
// Flow: a box accepted at a clock edge sits in the input register, and its result is
// loaded into the result register and shown on the output once that register is free.
// Throughput: one box per cycle; the input register stalls only when the result
// register is full and not taken.
// Reset: both stages empty, identity matrix, zero translation, reference box at origin.
`default_nettype none

module aabb_transform_overlap (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  aabb_pkg::aabb_in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output aabb_pkg::aabb_out_t                    out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [aabb_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [aabb_pkg::RegBits-1:0]           cfg_wdata_i
);
  import aabb_pkg::*;

  logic [RegBits-1:0] row_x_q, row_y_q, row_z_q;
  logic [RegBits-1:0] trans_q, ref_min_q, ref_max_q;

  logic      in_valid_q;
  aabb_in_t  in_q;
  logic      out_valid_q;
  aabb_out_t out_q;
  aabb_out_t out_d;
  logic      out_load;

  axis_res_t res_x, res_y, res_z;
  logic [NumAxes*CoordBits-1:0] lo_vec, hi_vec;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q   <= RowXReset;
      row_y_q   <= RowYReset;
      row_z_q   <= RowZReset;
      trans_q   <= '0;
      ref_min_q <= '0;
      ref_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRowX:   row_x_q   <= cfg_wdata_i;
        RegRowY:   row_y_q   <= cfg_wdata_i;
        RegRowZ:   row_z_q   <= cfg_wdata_i;
        RegTrans:  trans_q   <= cfg_wdata_i;
        RegRefMin: ref_min_q <= cfg_wdata_i;
        RegRefMax: ref_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the result register loads when the input register holds a word and it is free or being taken.
  assign out_load   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || out_load;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Local box corners, x in the low slot.
  assign lo_vec = {in_q.local_min_z, in_q.local_min_y, in_q.local_min_x};
  assign hi_vec = {in_q.local_max_z, in_q.local_max_y, in_q.local_max_x};

  // One unit per world axis.
  aabb_axis u_axis_x (
    .row_i     (row_x_q),
    .trans_i   (trans_q[0*CoordBits +: CoordBits]),
    .ref_min_i (ref_min_q[0*CoordBits +: CoordBits]),
    .ref_max_i (ref_max_q[0*CoordBits +: CoordBits]),
    .lo_i      (lo_vec),
    .hi_i      (hi_vec),
    .res_o     (res_x)
  );

  aabb_axis u_axis_y (
    .row_i     (row_y_q),
    .trans_i   (trans_q[1*CoordBits +: CoordBits]),
    .ref_min_i (ref_min_q[1*CoordBits +: CoordBits]),
    .ref_max_i (ref_max_q[1*CoordBits +: CoordBits]),
    .lo_i      (lo_vec),
    .hi_i      (hi_vec),
    .res_o     (res_y)
  );

  aabb_axis u_axis_z (
    .row_i     (row_z_q),
    .trans_i   (trans_q[2*CoordBits +: CoordBits]),
    .ref_min_i (ref_min_q[2*CoordBits +: CoordBits]),
    .ref_max_i (ref_max_q[2*CoordBits +: CoordBits]),
    .lo_i      (lo_vec),
    .hi_i      (hi_vec),
    .res_o     (res_z)
  );

  // Assemble the output word.
  always_comb begin
    out_d.world_min_x        = res_x.wmin;
    out_d.world_min_y        = res_y.wmin;
    out_d.world_min_z        = res_z.wmin;
    out_d.world_max_x        = res_x.wmax;
    out_d.world_max_y        = res_y.wmax;
    out_d.world_max_z        = res_z.wmax;
    out_d.overlaps_reference = res_x.hit && res_y.hit && res_z.hit;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input stage only back-pressures when both stages are full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full, blocked pipeline");

  // A held word in the input register keeps its payload until it moves on.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> (in_valid_q && $stable(in_q)))
    else $error("held input word changed or vanished");

  // Loading the result register always produces a valid word.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result register loaded but not valid");

  // The world box is never inverted, whatever the local box.
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.world_min_x <= out_q.world_max_x) &&
                     (out_q.world_min_y <= out_q.world_max_y) &&
                     (out_q.world_min_z <= out_q.world_max_z)))
    else $error("world box minimum above maximum");

endmodule

`default_nettype wire

@@ hdl/aabb_axis.sv @@
`default_nettype none

// One world axis: one product per box corner coordinate, per-column
// min and max, translation, saturation and the reference interval test.
module aabb_axis (
  input  logic [aabb_pkg::RegBits-1:0]              row_i,
  input  logic signed [aabb_pkg::CoordBits-1:0]     trans_i,
  input  logic signed [aabb_pkg::CoordBits-1:0]     ref_min_i,
  input  logic signed [aabb_pkg::CoordBits-1:0]     ref_max_i,
  input  logic [aabb_pkg::NumAxes*aabb_pkg::CoordBits-1:0] lo_i,
  input  logic [aabb_pkg::NumAxes*aabb_pkg::CoordBits-1:0] hi_i,
  output aabb_pkg::axis_res_t                       res_o
);
  import aabb_pkg::*;

  localparam coord_t MaxCoord = {1'b0, {(CoordBits-1){1'b1}}};
  localparam coord_t MinCoord = {1'b1, {(CoordBits-1){1'b0}}};

  logic signed [ProdBits-1:0] prod_lo  [NumAxes];
  logic signed [ProdBits-1:0] prod_hi  [NumAxes];
  logic signed [TermBits-1:0] term_lo  [NumAxes];
  logic signed [TermBits-1:0] term_hi  [NumAxes];
  logic signed [TermBits-1:0] term_min [NumAxes];
  logic signed [TermBits-1:0] term_max [NumAxes];
  logic signed [SumBits-1:0]  sum_min;
  logic signed [SumBits-1:0]  sum_max;
  coord_t                     wmin;
  coord_t                     wmax;

  // Clamp an exact sum to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [SumBits-1:0] v);
    logic [SumBits-CoordBits:0] top;
    begin
      top = v[SumBits-1:CoordBits-1];
      if ((&top) || !(|top)) begin
        sat_coord = v[CoordBits-1:0];
      end else if (v[SumBits-1]) begin
        sat_coord = MinCoord;
      end else begin
        sat_coord = MaxCoord;
      end
    end
  endfunction

  // Products, floor shift by the coefficient fraction, and per-column ordering.
  always_comb begin
    for (int j = 0; j < NumAxes; j++) begin
      prod_lo[j] = $signed(row_i[j*CoefBits +: CoefBits])
                 * $signed(lo_i[j*CoordBits +: CoordBits]);
      prod_hi[j] = $signed(row_i[j*CoefBits +: CoefBits])
                 * $signed(hi_i[j*CoordBits +: CoordBits]);
      term_lo[j] = prod_lo[j][ProdBits-1:FracShift];
      term_hi[j] = prod_hi[j][ProdBits-1:FracShift];
      if (term_lo[j] < term_hi[j]) begin
        term_min[j] = term_lo[j];
        term_max[j] = term_hi[j];
      end else begin
        term_min[j] = term_hi[j];
        term_max[j] = term_lo[j];
      end
    end
  end

  // Exact sums with the translation, then saturation.
  always_comb begin
    sum_min = SumBits'(trans_i) + SumBits'(term_min[0]) + SumBits'(term_min[1])
            + SumBits'(term_min[2]);
    sum_max = SumBits'(trans_i) + SumBits'(term_max[0]) + SumBits'(term_max[1])
            + SumBits'(term_max[2]);
    wmin = sat_coord(sum_min);
    wmax = sat_coord(sum_max);
  end

  // Inclusive interval overlap on the saturated values.
  assign res_o.wmin = wmin;
  assign res_o.wmax = wmax;
  assign res_o.hit  = (wmin <= ref_max_i) && (wmax >= ref_min_i);

endmodule

`default_nettype wire

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam int unsigned NumCfgRegs = 6;
  // Indexes past the last register; writes to them must have no effect.
  localparam logic [CfgIdxBits-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegSpareHi = 3'd7;

  localparam longint CoordMax = (longint'(1) << (CoordBits - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam logic [CoefBits-1:0] CoefMax = 16'h7FFF;
  localparam logic [CoefBits-1:0] CoefMin = 16'h8000;

  localparam int DrainCycles = 4;
  localparam int IdleLimit   = 2000;
  localparam int MaxReports  = 100;
  localparam int NumPhases   = 7;
  localparam int PhaseItems  = 75;
  localparam int StreamItems = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  aabb_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  aabb_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx   = '0;
  logic [RegBits-1:0]    cfg_wdata = '0;

  // Copy of the configuration as the block should hold it.
  logic [RegBits-1:0] cfg_shadow [NumCfgRegs];
  aabb_out_t expected_boxes [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  aabb_transform_overlap u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Signed coordinate held in slot k of a packed register.
  function automatic longint coord_slot(logic [RegBits-1:0] word, int k);
    return longint'($signed(word[k*CoordBits +: CoordBits]));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  // World box of one local box: per axis, translation plus the smaller and
  // larger of each floored product, then saturated; overlap is inclusive.
  function automatic aabb_out_t predict_world_box(aabb_in_t box);
    longint lo [NumAxes];
    longint hi [NumAxes];
    longint wmin [NumAxes];
    longint wmax [NumAxes];
    longint sum_min, sum_max, coef, a, b;
    logic hit;
    aabb_out_t res;
    lo[0] = box.local_min_x;
    lo[1] = box.local_min_y;
    lo[2] = box.local_min_z;
    hi[0] = box.local_max_x;
    hi[1] = box.local_max_y;
    hi[2] = box.local_max_z;
    hit = 1'b1;
    for (int i = 0; i < NumAxes; i++) begin
      sum_min = coord_slot(cfg_shadow[RegTrans], i);
      sum_max = sum_min;
      // Registers 0 to 2 are the matrix rows for world x, y and z.
      for (int j = 0; j < NumAxes; j++) begin
        coef = longint'($signed(cfg_shadow[i][j*CoefBits +: CoefBits]));
        a = (coef * lo[j]) >>> FracShift;
        b = (coef * hi[j]) >>> FracShift;
        sum_min += (a < b) ? a : b;
        sum_max += (a > b) ? a : b;
      end
      wmin[i] = clamp_coord(sum_min);
      wmax[i] = clamp_coord(sum_max);
      if (!(wmin[i] <= coord_slot(cfg_shadow[RegRefMax], i) &&
            wmax[i] >= coord_slot(cfg_shadow[RegRefMin], i)))
        hit = 1'b0;
    end
    res.world_min_x = coord_t'(wmin[0]);
    res.world_min_y = coord_t'(wmin[1]);
    res.world_min_z = coord_t'(wmin[2]);
    res.world_max_x = coord_t'(wmax[0]);
    res.world_max_y = coord_t'(wmax[1]);
    res.world_max_z = coord_t'(wmax[2]);
    res.overlaps_reference = hit;
    return res;
  endfunction

  function automatic logic [RegBits-1:0] pack_triple(longint x, longint y, longint z);
    return {CoordBits'(z), CoordBits'(y), CoordBits'(x)};
  endfunction

  function automatic aabb_in_t make_box(longint min_x, longint min_y, longint min_z,
                                        longint max_x, longint max_y, longint max_z);
    aabb_in_t box;
    box.local_min_x = coord_t'(min_x);
    box.local_min_y = coord_t'(min_y);
    box.local_min_z = coord_t'(min_z);
    box.local_max_x = coord_t'(max_x);
    box.local_max_y = coord_t'(max_y);
    box.local_max_z = coord_t'(max_z);
    return box;
  endfunction

  function automatic coord_t random_small();
    return coord_t'(longint'($urandom_range(4000)) - 2000);
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(7))
      0:       return coord_t'(CoordMax);
      1:       return coord_t'(CoordMin);
      2, 3:    return coord_t'($urandom);
      default: return random_small();
    endcase
  endfunction

  // Mostly well-ordered boxes; about one axis in ten is left as drawn.
  function automatic aabb_in_t random_box();
    coord_t lo [NumAxes];
    coord_t hi [NumAxes];
    coord_t tmp;
    for (int j = 0; j < NumAxes; j++) begin
      lo[j] = random_coord();
      hi[j] = random_coord();
      if ($urandom_range(9) != 0 && lo[j] > hi[j]) begin
        tmp = lo[j];
        lo[j] = hi[j];
        hi[j] = tmp;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // A tame row keeps each coefficient within plus or minus 1.0.
  function automatic logic [RegBits-1:0] random_row(bit tame);
    logic [CoefBits-1:0] c [NumAxes];
    for (int j = 0; j < NumAxes; j++)
      c[j] = tame ? CoefBits'(longint'($urandom_range(8192)) - 4096) : CoefBits'($urandom);
    return pack_triple(c[0], c[1], c[2]);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MaxReports)
      $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Output check, input capture and the no-progress watchdog.
  always @(posedge clk) begin : result_check
    aabb_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch("output word with no result expected");
        end else begin
          want = expected_boxes.pop_front();
          check_field("world_min_x", out_data.world_min_x, want.world_min_x);
          check_field("world_min_y", out_data.world_min_y, want.world_min_y);
          check_field("world_min_z", out_data.world_min_z, want.world_min_z);
          check_field("world_max_x", out_data.world_max_x, want.world_max_x);
          check_field("world_max_y", out_data.world_max_y, want.world_max_y);
          check_field("world_max_z", out_data.world_max_z, want.world_max_z);
          check_field("overlaps_reference", out_data.overlaps_reference,
                      want.overlaps_reference);
        end
      end
      if (in_valid && in_ready)
        expected_boxes.push_back(predict_world_box(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver back-pressure in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(6, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic pick_idling();
    gap_pct   = 20 * $urandom_range(2);
    stall_pct = 20 * $urandom_range(2);
  endtask

  // Starts and ends on a falling edge. Valid is left high so the next word can
  // follow directly; drain_results lowers it.
  task automatic send_box(aabb_in_t box);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= box;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_cfg_reg(logic [CfgIdxBits-1:0] idx, logic [RegBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < NumCfgRegs)
      cfg_shadow[idx] = value;
    @(negedge clk);
  endtask

  // Random settings; phases 2 and 3 use the largest and the most negative values.
  task automatic load_phase_config(int phase);
    bit tame;
    aabb_in_t ref_box;
    tame = (phase % 2 == 0);
    if (phase == 2) begin
      write_cfg_reg(RegRowX, pack_triple(CoefMax, CoefMax, CoefMax));
      write_cfg_reg(RegRowY, pack_triple(CoefMax, CoefMax, CoefMax));
      write_cfg_reg(RegRowZ, pack_triple(CoefMax, CoefMax, CoefMax));
      write_cfg_reg(RegTrans, pack_triple(CoordMax, CoordMax, CoordMax));
    end else if (phase == 3) begin
      write_cfg_reg(RegRowX, pack_triple(CoefMin, CoefMin, CoefMin));
      write_cfg_reg(RegRowY, pack_triple(CoefMin, CoefMin, CoefMin));
      write_cfg_reg(RegRowZ, pack_triple(CoefMin, CoefMin, CoefMin));
      write_cfg_reg(RegTrans, pack_triple(CoordMin, CoordMin, CoordMin));
    end else begin
      write_cfg_reg(RegRowX, random_row(tame));
      write_cfg_reg(RegRowY, random_row(tame));
      write_cfg_reg(RegRowZ, random_row(tame));
      if (tame)
        write_cfg_reg(RegTrans, pack_triple(random_small(), random_small(), random_small()));
      else
        write_cfg_reg(RegTrans, RegBits'({$urandom, $urandom}));
    end
    ref_box = random_box();
    write_cfg_reg(RegRefMin, pack_triple(ref_box.local_min_x, ref_box.local_min_y,
                                         ref_box.local_min_z));
    write_cfg_reg(RegRefMax, pack_triple(ref_box.local_max_x, ref_box.local_max_y,
                                         ref_box.local_max_z));
  endtask

  // Identity transform out of reset against a point reference at the origin.
  task automatic test_reset_identity();
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    send_box(make_box(64, 64, 64, 128, 128, 128));
    send_box(make_box(-128, -128, -128, -64, -64, -64));
    // Touching the reference point still counts as overlap.
    send_box(make_box(-64, 0, -64, 0, 64, 0));
    // Inverted box: the corner set is the same, so is the bounding box.
    send_box(make_box(100, 100, 100, -100, -100, -100));
    send_box(make_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    drain_results();
  endtask

  // Largest and most negative coefficients and translations drive saturation.
  task automatic test_extreme_transforms();
    write_cfg_reg(RegRowX, pack_triple(CoefMax, CoefMax, CoefMax));
    write_cfg_reg(RegRowY, pack_triple(CoefMax, CoefMax, CoefMax));
    write_cfg_reg(RegRowZ, pack_triple(CoefMax, CoefMax, CoefMax));
    write_cfg_reg(RegTrans, pack_triple(CoordMax, CoordMax, CoordMax));
    write_cfg_reg(RegRefMin, pack_triple(CoordMin, CoordMin, CoordMin));
    write_cfg_reg(RegRefMax, pack_triple(CoordMax, CoordMax, CoordMax));
    send_box(make_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    send_box(make_box(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin));
    send_box(make_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    drain_results();
    // Inverted reference box: overlap is set only when the world box spans the whole coordinate range.
    write_cfg_reg(RegRowX, pack_triple(CoefMin, CoefMin, CoefMin));
    write_cfg_reg(RegRowY, pack_triple(CoefMin, CoefMin, CoefMin));
    write_cfg_reg(RegRowZ, pack_triple(CoefMin, CoefMin, CoefMin));
    write_cfg_reg(RegTrans, pack_triple(CoordMin, CoordMin, CoordMin));
    write_cfg_reg(RegRefMin, pack_triple(CoordMax, CoordMax, CoordMax));
    write_cfg_reg(RegRefMax, pack_triple(CoordMin, CoordMin, CoordMin));
    send_box(make_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    drain_results();
  endtask

  // Fractional coefficients on odd and negative inputs check the floor of the
  // product shift; writes past the last register must change nothing.
  task automatic test_fractional_rounding();
    write_cfg_reg(RegRowX, pack_triple(16'h0800, 16'h0000, 16'h0000));
    write_cfg_reg(RegRowY, pack_triple(16'h0000, 16'hF800, 16'h0001));
    write_cfg_reg(RegRowZ, pack_triple(16'hFFFF, 16'h1000, 16'h0555));
    write_cfg_reg(RegTrans, pack_triple(-1, 3, 0));
    write_cfg_reg(RegRefMin, pack_triple(-10, -10, -10));
    write_cfg_reg(RegRefMax, pack_triple(10, 10, 10));
    send_box(make_box(-1, -3, -5, 1, 3, 5));
    send_box(make_box(-3, -1, -7, -3, -1, -7));
    send_box(make_box(5, 5, 5, -5, -5, -5));
    send_box(make_box(-12345, 777, -1, 2345, -777, 1));
    drain_results();
    write_cfg_reg(RegSpareLo, '1);
    write_cfg_reg(RegSpareHi, '1);
    send_box(make_box(-12345, 777, -1, 2345, -777, 1));
    drain_results();
  endtask

  // Random words over several settings, with a pause mid-phase until every
  // result has come back.
  task automatic test_random_phases();
    for (int phase = 0; phase < NumPhases; phase++) begin
      load_phase_config(phase);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 20 == 0) pick_idling();
        if (n == PhaseItems / 2) drain_results();
        send_box(random_box());
      end
      drain_results();
    end
  endtask

  // Full-rate stream with neither side idling.
  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    load_phase_config(0);
    for (int n = 0; n < StreamItems; n++)
      send_box(random_box());
    drain_results();
  endtask

  initial begin
    cfg_shadow[RegRowX]   = RowXReset;
    cfg_shadow[RegRowY]   = RowYReset;
    cfg_shadow[RegRowZ]   = RowZReset;
    cfg_shadow[RegTrans]  = '0;
    cfg_shadow[RegRefMin] = '0;
    cfg_shadow[RegRefMax] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pick_idling();
    test_reset_identity();
    test_extreme_transforms();
    test_fractional_rounding();
    test_random_phases();
    test_back_to_back();

    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
